// ===== hw/rtl/adsr_eg_pkg.sv =====
package adsr_eg_pkg;

    localparam int STEP_W     = 23;
    localparam int ENV_W      = 23;
    localparam int LOOP_W     = 24;
    localparam int PULSE_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [STEP_W-1:0]  ATTACK_STEP_RST     = 23'd42;
    localparam logic [STEP_W-1:0]  DECAY_STEP_RST      = 23'd21;
    localparam logic [STEP_W-1:0]  SUSTAIN_LEVEL_RST   = 23'd2097152;
    localparam logic [STEP_W-1:0]  RELEASE_STEP_RST    = 23'd87;
    localparam logic               LOOP_ENABLE_RST     = 1'b0;
    localparam logic [LOOP_W-1:0]  LOOP_GATE_TICKS_RST = 24'd96000;
    localparam logic [PULSE_W-1:0] END_PULSE_TICKS_RST = 10'd48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_STEP     = 3'd0,
        CFG_DECAY_STEP      = 3'd1,
        CFG_SUSTAIN_LEVEL   = 3'd2,
        CFG_RELEASE_STEP    = 3'd3,
        CFG_LOOP_ENABLE     = 3'd4,
        CFG_LOOP_GATE_TICKS = 3'd5,
        CFG_END_PULSE_TICKS = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        STAGE_ATTACK  = 2'd0,
        STAGE_DECAY   = 2'd1,
        STAGE_SUSTAIN = 2'd2,
        STAGE_RELEASE = 2'd3
    } stage_t;

    typedef struct packed {
        logic [STEP_W-1:0]  attack_step;
        logic [STEP_W-1:0]  decay_step;
        logic [STEP_W-1:0]  sustain_level;
        logic [STEP_W-1:0]  release_step;
        logic               loop_enable;
        logic [LOOP_W-1:0]  loop_gate_ticks;
        logic [PULSE_W-1:0] end_pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic gate_level;
        logic gate_patched;
    } tick_t;

    typedef struct packed {
        logic [ENV_W-1:0] envelope;
        logic             end_of_release;
        logic             active;
        logic [1:0]       stage;
    } env_result_t;

    // gate as seen by the envelope this tick
    typedef struct packed {
        logic source;
        logic gate;
    } gate_info_t;

    typedef struct packed {
        stage_t             phase;
        logic               running;
        logic               last_gate;
        logic [PULSE_W-1:0] end_countdown;
    } ctl_state_t;

endpackage

// ===== hw/rtl/adsr_eg_regs.sv =====
module adsr_eg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adsr_eg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsr_eg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output adsr_eg_pkg::cfg_t                   cfg
);
    import adsr_eg_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step     <= ATTACK_STEP_RST;
            cfg_reg.decay_step      <= DECAY_STEP_RST;
            cfg_reg.sustain_level   <= SUSTAIN_LEVEL_RST;
            cfg_reg.release_step    <= RELEASE_STEP_RST;
            cfg_reg.loop_enable     <= LOOP_ENABLE_RST;
            cfg_reg.loop_gate_ticks <= LOOP_GATE_TICKS_RST;
            cfg_reg.end_pulse_ticks <= END_PULSE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ATTACK_STEP:     cfg_reg.attack_step     <= cfg_data[STEP_W-1:0];
                CFG_DECAY_STEP:      cfg_reg.decay_step      <= cfg_data[STEP_W-1:0];
                CFG_SUSTAIN_LEVEL:   cfg_reg.sustain_level   <= cfg_data[STEP_W-1:0];
                CFG_RELEASE_STEP:    cfg_reg.release_step    <= cfg_data[STEP_W-1:0];
                CFG_LOOP_ENABLE:     cfg_reg.loop_enable     <= cfg_data[0];
                CFG_LOOP_GATE_TICKS: cfg_reg.loop_gate_ticks <= cfg_data[LOOP_W-1:0];
                CFG_END_PULSE_TICKS: cfg_reg.end_pulse_ticks <= cfg_data[PULSE_W-1:0];
                default:             ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/adsr_eg_gate.sv =====
module adsr_eg_gate (
    input  adsr_eg_pkg::tick_t                tick,
    input  logic                              loop_enable,
    input  logic [adsr_eg_pkg::LOOP_W-1:0]    loop_gate_ticks,
    input  logic [adsr_eg_pkg::LOOP_W-1:0]    loop_countdown,
    input  logic                              running,
    output adsr_eg_pkg::gate_info_t           gate_info,
    output logic [adsr_eg_pkg::LOOP_W-1:0]    loop_countdown_next
);
    import adsr_eg_pkg::*;

    always_comb
    begin
        gate_info.source    = tick.gate_patched || loop_enable;
        gate_info.gate      = 1'b0;
        loop_countdown_next = loop_countdown;
        if (tick.gate_patched)
        begin
            gate_info.gate = tick.gate_level;
        end
        else if (loop_enable)
        begin
            gate_info.gate = (loop_countdown != '0);
            if (loop_countdown != '0)
            begin
                loop_countdown_next = loop_countdown - LOOP_W'(1);
            end
            else if (!running)
            begin
                // re-arm internal gate while idle
                loop_countdown_next = loop_gate_ticks;
            end
        end
    end

endmodule

// ===== hw/rtl/adsr_eg_env.sv =====
module adsr_eg_env #(
    parameter int LEVEL_FRAC_BITS = 22
) (
    input  adsr_eg_pkg::gate_info_t       gate_info,
    input  adsr_eg_pkg::cfg_t             cfg,
    input  logic [LEVEL_FRAC_BITS:0]      level,
    input  adsr_eg_pkg::ctl_state_t       ctl,
    output logic [LEVEL_FRAC_BITS:0]      level_next,
    output adsr_eg_pkg::ctl_state_t       ctl_next,
    output adsr_eg_pkg::env_result_t      result
);
    import adsr_eg_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    // compare/add width covering both level and 23-bit steps plus carry
    localparam int CW = ((LW > STEP_W) ? LW : STEP_W) + 1;
    localparam logic [LW-1:0] FullScale = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic [LW-1:0]      lvl;
    logic [CW-1:0]      lvl_w;
    logic [CW-1:0]      sum_w;
    logic [CW-1:0]      dstep_w;
    logic [CW-1:0]      env_w;
    logic               finish;
    logic [PULSE_W-1:0] ec_load;
    logic               pulse;

    always_comb
    begin
        lvl      = level;
        ctl_next = ctl;
        finish   = 1'b0;
        lvl_w    = '0;
        sum_w    = '0;
        dstep_w  = '0;

        if (gate_info.source)
        begin
            if (gate_info.gate && !ctl.last_gate)
            begin
                ctl_next.phase   = STAGE_ATTACK;
                ctl_next.running = 1'b1;
                lvl              = '0;
            end
            ctl_next.last_gate = gate_info.gate;

            if (ctl_next.running)
            begin
                lvl_w = CW'(lvl);
                if (gate_info.gate)
                begin
                    if (ctl_next.phase == STAGE_ATTACK && lvl == FullScale
                        && cfg.attack_step != '0)
                    begin
                        ctl_next.phase = STAGE_DECAY;
                    end
                    if (ctl_next.phase == STAGE_DECAY
                        && lvl_w <= CW'(cfg.sustain_level) && cfg.decay_step != '0)
                    begin
                        ctl_next.phase = STAGE_SUSTAIN;
                    end
                    unique case (ctl_next.phase)
                        STAGE_ATTACK:
                        begin
                            sum_w = lvl_w + CW'(cfg.attack_step);
                            lvl   = (sum_w > CW'(FullScale)) ? FullScale : sum_w[LW-1:0];
                        end
                        STAGE_DECAY:
                        begin
                            dstep_w = CW'(cfg.decay_step);
                            sum_w   = (lvl_w > dstep_w) ? (lvl_w - dstep_w) : '0;
                            lvl     = sum_w[LW-1:0];
                        end
                        STAGE_SUSTAIN:
                        begin
                        end
                        default:
                        begin
                            dstep_w = CW'(cfg.release_step);
                            sum_w   = (lvl_w > dstep_w) ? (lvl_w - dstep_w) : '0;
                            lvl     = sum_w[LW-1:0];
                        end
                    endcase
                end
                else
                begin
                    ctl_next.phase = STAGE_RELEASE;
                    if (lvl == '0)
                    begin
                        ctl_next.running = 1'b0;
                        finish           = 1'b1;
                    end
                    else
                    begin
                        dstep_w = CW'(cfg.release_step);
                        sum_w   = (lvl_w > dstep_w) ? (lvl_w - dstep_w) : '0;
                        lvl     = sum_w[LW-1:0];
                    end
                end
            end
        end

        // end pulse: load on finish if longer than the count left, then sample and count down
        ec_load = (finish && cfg.end_pulse_ticks > ctl.end_countdown)
                ? cfg.end_pulse_ticks : ctl.end_countdown;
        pulse   = (ec_load != '0);
        ctl_next.end_countdown = pulse ? (ec_load - PULSE_W'(1)) : ec_load;
    end

    assign level_next = lvl;
    assign env_w      = CW'(lvl);

    assign result.envelope       = env_w[ENV_W-1:0];
    assign result.end_of_release = pulse;
    assign result.active         = ctl_next.running;
    assign result.stage          = ctl_next.phase;

endmodule

// ===== hw/rtl/adsr_envelope_generator_core.sv =====
// Linear ADSR envelope generator. Each tick transaction is one audio sample:
// it carries the external gate level and whether that gate is patched, and
// yields exactly one result transaction (envelope level in unsigned Q1.22 with
// 1<<LEVEL_FRAC_BITS as full scale, end-of-release pulse, active flag, stage).
// Throughput is one tick per clock while the result stage is not stalled; a
// tick passes the input register, then one pass of compare/add logic into the
// result register. A stalled result stage backs up into tick_stall only once
// the input register is full. Configuration writes are always ready and must
// only be issued while no tick is in flight.
module adsr_envelope_generator_core #(
    parameter int LEVEL_FRAC_BITS = 22
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  adsr_eg_pkg::tick_t                  tick,
    output logic                                env_valid,
    input  logic                                env_stall,
    output adsr_eg_pkg::env_result_t            env,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adsr_eg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsr_eg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adsr_eg_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam logic [LW-1:0] FullScale = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    cfg_t               cfg;
    logic               s1_valid_reg;
    tick_t              s1_data_reg;
    logic               env_valid_reg;
    env_result_t        env_data_reg;
    logic [LW-1:0]      level_reg;
    logic [LW-1:0]      level_next;
    ctl_state_t         ctl_reg;
    ctl_state_t         ctl_next;
    logic [LOOP_W-1:0]  loop_countdown_reg;
    logic [LOOP_W-1:0]  loop_countdown_next;
    gate_info_t         gate_info;
    env_result_t        result;
    logic               out_ready;
    logic               accept_tick;
    logic               advance;

    adsr_eg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_eg_gate u_gate (
        .tick                (s1_data_reg),
        .loop_enable         (cfg.loop_enable),
        .loop_gate_ticks     (cfg.loop_gate_ticks),
        .loop_countdown      (loop_countdown_reg),
        .running             (ctl_reg.running),
        .gate_info           (gate_info),
        .loop_countdown_next (loop_countdown_next)
    );

    adsr_eg_env #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_env (
        .gate_info  (gate_info),
        .cfg        (cfg),
        .level      (level_reg),
        .ctl        (ctl_reg),
        .level_next (level_next),
        .ctl_next   (ctl_next),
        .result     (result)
    );

    assign out_ready   = !env_valid_reg || !env_stall;
    assign tick_stall  = s1_valid_reg && !out_ready;
    assign accept_tick = tick_valid && !tick_stall;
    assign advance     = s1_valid_reg && out_ready;

    assign env_valid = env_valid_reg;
    assign env       = env_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            env_valid_reg      <= 1'b0;
            level_reg          <= '0;
            ctl_reg.phase      <= STAGE_ATTACK;
            ctl_reg.running    <= 1'b0;
            ctl_reg.last_gate  <= 1'b0;
            ctl_reg.end_countdown <= '0;
            loop_countdown_reg <= '0;
        end
        else
        begin
            if (accept_tick)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                env_valid_reg      <= 1'b1;
                level_reg          <= level_next;
                ctl_reg            <= ctl_next;
                loop_countdown_reg <= loop_countdown_next;
            end
            else if (!env_stall)
            begin
                env_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_tick)
        begin
            s1_data_reg <= tick;
        end
        if (advance)
        begin
            env_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FullScale)
        else $error("envelope level above full scale");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(level_reg) && $stable(ctl_reg) && $stable(loop_countdown_reg))
        else $error("envelope state changed without a tick transaction");

    a_finish_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ctl_reg.running) |-> level_reg == '0)
        else $error("envelope stopped at nonzero level");

    a_pulse_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.end_countdown > $past(ctl_reg.end_countdown) |-> $fell(ctl_reg.running))
        else $error("end pulse armed without release finishing");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> s1_valid_reg && env_valid_reg)
        else $error("tick stalled with room in the pipeline");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import adsr_eg_pkg::*;

    localparam int FRAC_BITS = 22;
    localparam int FULL      = 1 << FRAC_BITS;
    localparam int LIMIT     = 200000;
    localparam int HOLD_AT   = 400;
    localparam int HOLD_LEN  = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  tick_valid = 1'b0;
    logic                  tick_stall;
    tick_t                 tick = '0;
    logic                  env_valid;
    logic                  env_stall = 1'b0;
    env_result_t           env;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tick_t       ticks_todo[$];
    env_result_t env_due[$];

    int errors = 0;
    int cycles = 0;
    int ticks_accepted = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm = 1'b0;

    // predictor state and its copy of the registers
    cfg_t        cfg_m;
    logic [24:0] lvl = '0;
    stage_t      stg = STAGE_ATTACK;
    logic        run_q = 1'b0;
    logic        gate_q = 1'b0;
    logic [23:0] loop_cnt = '0;
    logic [9:0]  pulse_cnt = '0;

    adsr_envelope_generator_core #(
        .LEVEL_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .env_valid  (env_valid),
        .env_stall  (env_stall),
        .env        (env),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic env_result_t next_envelope(tick_t t);
        env_result_t r;
        logic        src;
        logic        gate;
        logic        pulse;
        src = t.gate_patched || cfg_m.loop_enable;
        gate = 1'b0;
        if (t.gate_patched)
        begin
            gate = t.gate_level;
        end
        else if (cfg_m.loop_enable)
        begin
            // internal gate: high while the countdown runs, re-armed when idle
            gate = loop_cnt != 0;
            if (gate)
                loop_cnt = loop_cnt - 1'b1;
            if (!gate && !run_q)
                loop_cnt = cfg_m.loop_gate_ticks;
        end
        if (src)
        begin
            if (gate && !gate_q)
            begin
                stg = STAGE_ATTACK;
                lvl = '0;
                run_q = 1'b1;
            end
            gate_q = gate;
            if (run_q)
            begin
                if (gate)
                begin
                    if (stg == STAGE_ATTACK && lvl >= FULL && cfg_m.attack_step != 0)
                        stg = STAGE_DECAY;
                    if (stg == STAGE_DECAY && lvl <= cfg_m.sustain_level
                        && cfg_m.decay_step != 0)
                        stg = STAGE_SUSTAIN;
                end
                else
                begin
                    stg = STAGE_RELEASE;
                end
                if (!gate && lvl == 0)
                begin
                    // release done: stop, no extra step, start end pulse
                    run_q = 1'b0;
                    if (cfg_m.end_pulse_ticks > pulse_cnt)
                        pulse_cnt = cfg_m.end_pulse_ticks;
                end
                else
                begin
                    case (stg)
                        STAGE_ATTACK:
                        begin
                            lvl = lvl + cfg_m.attack_step;
                            if (lvl > FULL)
                                lvl = FULL;
                        end
                        STAGE_DECAY:
                            lvl = (lvl > cfg_m.decay_step) ? lvl - cfg_m.decay_step : '0;
                        STAGE_SUSTAIN:
                            ;
                        default:
                            lvl = (lvl > cfg_m.release_step) ? lvl - cfg_m.release_step : '0;
                    endcase
                end
            end
        end
        pulse = pulse_cnt != 0;
        if (pulse)
            pulse_cnt = pulse_cnt - 1'b1;
        r.envelope = lvl[ENV_W-1:0];
        r.end_of_release = pulse;
        r.active = run_q;
        r.stage = stg;
        return r;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= 50)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic void queue_tick(bit gate_level, bit gate_patched);
        tick_t t;
        t.gate_level = gate_level;
        t.gate_patched = gate_patched;
        ticks_todo.push_back(t);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ATTACK_STEP:     cfg_m.attack_step = data[STEP_W-1:0];
            CFG_DECAY_STEP:      cfg_m.decay_step = data[STEP_W-1:0];
            CFG_SUSTAIN_LEVEL:   cfg_m.sustain_level = data[STEP_W-1:0];
            CFG_RELEASE_STEP:    cfg_m.release_step = data[STEP_W-1:0];
            CFG_LOOP_ENABLE:     cfg_m.loop_enable = data[0];
            CFG_LOOP_GATE_TICKS: cfg_m.loop_gate_ticks = data[LOOP_W-1:0];
            CFG_END_PULSE_TICKS: cfg_m.end_pulse_ticks = data[PULSE_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic load_settings(logic [23:0] atk, logic [23:0] dec, logic [23:0] sus,
                                 logic [23:0] rel, logic [23:0] loop_on,
                                 logic [23:0] loop_len, logic [23:0] pulse_len);
        write_reg(CFG_ATTACK_STEP, atk);
        write_reg(CFG_DECAY_STEP, dec);
        write_reg(CFG_SUSTAIN_LEVEL, sus);
        write_reg(CFG_RELEASE_STEP, rel);
        write_reg(CFG_LOOP_ENABLE, loop_on);
        write_reg(CFG_LOOP_GATE_TICKS, loop_len);
        write_reg(CFG_END_PULSE_TICKS, pulse_len);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (ticks_todo.size() != 0 || tick_valid || env_due.size() != 0);
    endtask

    // mostly gate pulses with random lengths, some unpatched runs, some noise
    task automatic run_traffic(int n);
        int cnt;
        int kind;
        int len;
        cnt = 0;
        @(negedge clk);
        while (cnt < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                len = $urandom_range(1, 30);
                if (len > n - cnt)
                    len = n - cnt;
                repeat (len) queue_tick(1'b1, 1'b1);
                cnt += len;
                len = $urandom_range(1, 40);
                if (len > n - cnt)
                    len = n - cnt;
                repeat (len) queue_tick(1'b0, 1'b1);
                cnt += len;
            end
            else if (kind < 9)
            begin
                len = $urandom_range(1, 40);
                if (len > n - cnt)
                    len = n - cnt;
                repeat (len) queue_tick($urandom_range(0, 1), 1'b0);
                cnt += len;
            end
            else
            begin
                len = $urandom_range(1, 10);
                if (len > n - cnt)
                    len = n - cnt;
                repeat (len) queue_tick($urandom_range(0, 1), $urandom_range(0, 1));
                cnt += len;
            end
        end
        wait_drained();
    endtask

    // tick driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
            begin
                env_due.push_back(next_envelope(tick));
                ticks_accepted <= ticks_accepted + 1;
            end
            if (!tick_valid || !tick_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    tick_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    tx_gap <= $urandom_range(0, 8);
                    tick_valid <= 1'b0;
                end
                else if (ticks_todo.size() != 0)
                begin
                    tick <= ticks_todo.pop_front();
                    tick_valid <= 1'b1;
                end
                else
                begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the pipeline fills and backs up
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && ticks_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        env_result_t want;
        if (!rst_n)
        begin
            env_stall <= 1'b0;
        end
        else
        begin
            if (env_valid && !env_stall)
            begin
                if (env_due.size() == 0)
                begin
                    report_error($sformatf("result transaction with nothing expected: %0d",
                                           env.envelope));
                end
                else
                begin
                    want = env_due.pop_front();
                    if (env.envelope !== want.envelope)
                        report_error($sformatf("envelope: expected %0d, got %0d",
                                               want.envelope, env.envelope));
                    if (env.end_of_release !== want.end_of_release)
                        report_error($sformatf("end_of_release: expected %0b, got %0b",
                                               want.end_of_release, env.end_of_release));
                    if (env.active !== want.active)
                        report_error($sformatf("active: expected %0b, got %0b",
                                               want.active, env.active));
                    if (env.stage !== want.stage)
                        report_error($sformatf("stage: expected %0d, got %0d",
                                               want.stage, env.stage));
                end
            end
            if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                env_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                env_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rx_gap <= $urandom_range(0, 8);
                env_stall <= 1'b1;
            end
            else
            begin
                env_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        cfg_m.attack_step = ATTACK_STEP_RST;
        cfg_m.decay_step = DECAY_STEP_RST;
        cfg_m.sustain_level = SUSTAIN_LEVEL_RST;
        cfg_m.release_step = RELEASE_STEP_RST;
        cfg_m.loop_enable = LOOP_ENABLE_RST;
        cfg_m.loop_gate_ticks = LOOP_GATE_TICKS_RST;
        cfg_m.end_pulse_ticks = END_PULSE_TICKS_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: frozen without a source, short attack, release to zero
        @(negedge clk);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        repeat (3) queue_tick(1'b0, 1'b1);
        wait_drained();

        // fast settings: attack overshoots full scale, decay lands on sustain
        load_settings(1398102, 1048576, 1048576, 524288, 0, 4, 3);
        @(negedge clk);
        repeat (8) queue_tick(1'b1, 1'b1);
        repeat (5) queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);   // retrigger in the middle of release
        queue_tick(1'b1, 1'b0);
        wait_drained();

        // full-scale steps, loop gate and end pulse of one tick
        load_settings(FULL, FULL, 0, FULL, 1, 1, 1);
        run_traffic(100);
        // smallest steps, longest loop gate and end pulse
        load_settings(1, 0, FULL, 0, 1, 24'hFFFFFF, 10'h3FF);
        run_traffic(60);
        // all-ones fields, zero loop and pulse lengths
        load_settings(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 1, 0, 0);
        run_traffic(60);
        // no attack step: level stays at zero, release ends at once
        load_settings(0, FULL / 8, FULL / 2, FULL / 8, 0, 5, 10'h3FF);
        run_traffic(40);

        repeat (4)
        begin
            load_settings($urandom_range(FULL / 16, FULL / 2), $urandom_range(FULL / 32, FULL / 4),
                          $urandom_range(0, FULL), $urandom_range(FULL / 32, FULL / 4),
                          $urandom_range(0, 1), $urandom_range(1, 40), $urandom_range(1, 60));
            run_traffic(120);
        end

        calm = 1'b1;
        load_settings(FULL / 4, FULL / 8, FULL / 3, FULL / 8, 1, 10, 5);
        run_traffic(100);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
